>>> rtl/ssvt_pkg.sv
`timescale 1ns / 1ps

package ssvt_pkg;

  localparam int DEFAULT_CAPACITY   = 64;
  localparam int DEFAULT_INDEX_BITS = 20;

  localparam int ACTION_BITS = 3;
  localparam int VALUE_BITS  = 32;
  localparam int STATUS_BITS = 2;

  localparam logic [ACTION_BITS-1:0] ACT_SET   = 3'd0;
  localparam logic [ACTION_BITS-1:0] ACT_GET   = 3'd1;
  localparam logic [ACTION_BITS-1:0] ACT_ADD   = 3'd2;
  localparam logic [ACTION_BITS-1:0] ACT_SUB   = 3'd3;
  localparam logic [ACTION_BITS-1:0] ACT_CLEAR = 3'd4;

  localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd2;

endpackage

>>> rtl/sorted_sparse_vector_table.sv
`timescale 1ns / 1ps

// Sorted sparse vector table. Holds up to CAPACITY nonzero (index, value)
// pairs in one RAM, sorted by ascending index. Each input transaction carries
// an action (set, get, add, subtract, clear) and returns exactly one result
// transaction with the read value, a status code and the entry count after
// the action. One item is worked on at a time. A lookup scans the RAM from
// slot 0, one entry per cycle, until it reaches the first index at or above
// the requested one; an insert or a removal then shifts the tail of the table
// one slot, again one entry per cycle through the single read and write
// ports. A get or an overwrite ends after the scan, a removal shifts the tail
// down, and an insert shifts the tail up and then writes the new entry. Clear,
// out-of-range and unused actions skip the scan and go straight to the
// result. The block is ready for the next input transaction when m_tvalid
// rises. The result waits in an output register, and a new input
// transaction is taken while it waits; a finished item stalls only while an
// earlier result is still waiting. The user must write vector_length only
// while the block is idle; the block itself does not enforce this. Reset
// needs no clearing pass since only slots below the entry count are
// ever read.
module sorted_sparse_vector_table #(
  parameter int CAPACITY   = ssvt_pkg::DEFAULT_CAPACITY,
  parameter int INDEX_BITS = ssvt_pkg::DEFAULT_INDEX_BITS,
  localparam int COUNT_BITS = $clog2(CAPACITY + 1),
  localparam int IN_BITS    = ((ssvt_pkg::ACTION_BITS + INDEX_BITS
                               + ssvt_pkg::VALUE_BITS + 7) / 8) * 8,
  localparam int OUT_BITS   = ((ssvt_pkg::VALUE_BITS + ssvt_pkg::STATUS_BITS
                               + COUNT_BITS + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration: logical vector length, valid indices are below it
  input  logic                  vector_length_we,
  input  logic [INDEX_BITS:0]   vector_length,
  // input stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // s_tdata, from bit 0: action, index, value, zero fill
  input  logic [IN_BITS-1:0]    s_tdata,
  // output stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // m_tdata, from bit 0: read_value, status, entry_count, zero fill
  output logic [OUT_BITS-1:0]   m_tdata
);

  localparam int AB  = $clog2(CAPACITY);
  localparam int VB  = ssvt_pkg::VALUE_BITS;
  localparam int AW  = ssvt_pkg::ACTION_BITS;
  localparam int SB  = ssvt_pkg::STATUS_BITS;
  localparam int EW  = INDEX_BITS + VB;

  // sequencer states
  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_SEARCH    = 3'd1;
  localparam logic [2:0] S_DECIDE    = 3'd2;
  localparam logic [2:0] S_SHIFT_DN  = 3'd3;
  localparam logic [2:0] S_SHIFT_UP  = 3'd4;
  localparam logic [2:0] S_WRITE_NEW = 3'd5;
  localparam logic [2:0] S_FINISH    = 3'd6;

  logic [2:0]            state;
  logic [INDEX_BITS:0]   vlen;
  logic [COUNT_BITS-1:0] cnt;

  // latched item
  logic [AW-1:0]         act;
  logic [INDEX_BITS-1:0] idx;
  logic [VB-1:0]         val;

  // scan pointer and "RAM output holds the entry just read" flag
  logic [COUNT_BITS-1:0] scan;
  logic                  chk;

  // search result
  logic [COUNT_BITS-1:0] slot;
  logic                  present;
  logic [VB-1:0]         old_val;

  // pending result
  logic [VB-1:0]         res_rd;
  logic [SB-1:0]         res_st;

  // output register
  logic [VB-1:0]         out_rd;
  logic [SB-1:0]         out_st;
  logic [COUNT_BITS-1:0] out_cnt;
  logic                  out_load;

  // RAM port signals
  logic                  mem_we;
  logic [AB-1:0]         mem_waddr;
  logic [EW-1:0]         mem_wdata;
  logic                  mem_re;
  logic [AB-1:0]         mem_raddr;
  logic [EW-1:0]         mem_rdata;

  logic [INDEX_BITS-1:0] q_pos;
  logic [VB-1:0]         q_val;
  logic                  hit;
  logic [VB-1:0]         cur_val;
  logic [VB-1:0]         new_val;
  logic [COUNT_BITS-1:0] scan_m1;
  logic [COUNT_BITS-1:0] scan_m2;
  logic [COUNT_BITS-1:0] scan_p1;

  logic [AW-1:0]         in_action;
  logic [INDEX_BITS-1:0] in_index;
  logic [VB-1:0]         in_value;

  assign in_action = s_tdata[AW-1:0];
  assign in_index  = s_tdata[AW +: INDEX_BITS];
  assign in_value  = s_tdata[AW + INDEX_BITS +: VB];

  assign s_tready = (state == S_IDLE);

  // result moves into the output register when that register is free
  assign out_load = (state == S_FINISH) && (!m_tvalid || m_tready);

  always_comb begin
    m_tdata = '0;
    m_tdata[VB-1:0]              = out_rd;
    m_tdata[VB +: SB]            = out_st;
    m_tdata[VB + SB +: COUNT_BITS] = out_cnt;
  end

  assign q_pos   = mem_rdata[INDEX_BITS-1:0];
  assign q_val   = mem_rdata[INDEX_BITS +: VB];
  // first stored index at or above the target ends the scan
  assign hit     = chk && (q_pos >= idx);
  assign cur_val = present ? old_val : '0;
  assign scan_m1 = scan - 1'b1;
  assign scan_m2 = scan - 2'd2;
  assign scan_p1 = scan + 1'b1;

  always_comb begin
    case (act)
      ssvt_pkg::ACT_ADD: new_val = cur_val + val;
      ssvt_pkg::ACT_SUB: new_val = cur_val - val;
      default:           new_val = val;
    endcase
  end

  // RAM access per state
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = slot[AB-1:0];
    mem_wdata = {val, idx};
    mem_re    = 1'b0;
    mem_raddr = scan[AB-1:0];
    case (state)
      S_SEARCH: begin
        mem_re = !hit && (scan != cnt);
      end
      S_DECIDE: begin
        // overwrite in place
        mem_we    = (act != ssvt_pkg::ACT_GET) && (new_val != '0) && present;
        mem_wdata = {new_val, idx};
      end
      S_SHIFT_DN: begin
        // entry read at scan-1 moves down to scan-2
        mem_we    = chk;
        mem_waddr = scan_m2[AB-1:0];
        mem_wdata = mem_rdata;
        mem_re    = (scan != cnt);
      end
      S_SHIFT_UP: begin
        // entry read at scan moves up to scan+1
        mem_we    = chk;
        mem_waddr = scan_p1[AB-1:0];
        mem_wdata = mem_rdata;
        mem_re    = (scan != slot);
        mem_raddr = scan_m1[AB-1:0];
      end
      S_WRITE_NEW: begin
        mem_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  ssvt_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      vlen     <= {1'b1, {INDEX_BITS{1'b0}}};
      cnt      <= '0;
      chk      <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (vector_length_we) begin
        vlen <= vector_length;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            act    <= in_action;
            idx    <= in_index;
            val    <= in_value;
            res_rd <= '0;
            scan   <= '0;
            chk    <= 1'b0;
            case (in_action)
              ssvt_pkg::ACT_CLEAR: begin
                cnt    <= '0;
                res_st <= ssvt_pkg::ST_OK;
                state  <= S_FINISH;
              end
              ssvt_pkg::ACT_SET, ssvt_pkg::ACT_GET,
              ssvt_pkg::ACT_ADD, ssvt_pkg::ACT_SUB: begin
                if ({1'b0, in_index} >= vlen) begin
                  res_st <= ssvt_pkg::ST_RANGE;
                  state  <= S_FINISH;
                end else begin
                  res_st <= ssvt_pkg::ST_OK;
                  state  <= S_SEARCH;
                end
              end
              default: begin
                res_st <= ssvt_pkg::ST_OK;
                state  <= S_FINISH;
              end
            endcase
          end
        end

        S_SEARCH: begin
          if (hit) begin
            slot    <= scan_m1;
            present <= (q_pos == idx);
            old_val <= q_val;
            state   <= S_DECIDE;
          end else if (scan == cnt) begin
            slot    <= cnt;
            present <= 1'b0;
            state   <= S_DECIDE;
          end else begin
            scan <= scan_p1;
            chk  <= 1'b1;
          end
        end

        S_DECIDE: begin
          chk <= 1'b0;
          if (act == ssvt_pkg::ACT_GET) begin
            res_rd <= cur_val;
            state  <= S_FINISH;
          end else if (new_val == '0) begin
            // zero sum: remove if stored, else nothing to do
            if (present) begin
              scan  <= slot + 1'b1;
              state <= S_SHIFT_DN;
            end else begin
              state <= S_FINISH;
            end
          end else if (present) begin
            state <= S_FINISH;
          end else if (cnt == COUNT_BITS'(CAPACITY)) begin
            res_st <= ssvt_pkg::ST_FULL;
            state  <= S_FINISH;
          end else begin
            val   <= new_val;
            scan  <= cnt;
            state <= S_SHIFT_UP;
          end
        end

        S_SHIFT_DN: begin
          if (scan == cnt) begin
            cnt   <= cnt - 1'b1;
            chk   <= 1'b0;
            state <= S_FINISH;
          end else begin
            scan <= scan_p1;
            chk  <= 1'b1;
          end
        end

        S_SHIFT_UP: begin
          if (scan == slot) begin
            chk   <= 1'b0;
            state <= S_WRITE_NEW;
          end else begin
            scan <= scan_m1;
            chk  <= 1'b1;
          end
        end

        S_WRITE_NEW: begin
          cnt   <= cnt + 1'b1;
          state <= S_FINISH;
        end

        S_FINISH: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_rd  <= res_rd;
      out_st  <= res_st;
      out_cnt <= cnt;
    end
  end

endmodule

>>> rtl/ssvt_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port, registered read.
module ssvt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> tb/sv/sorted_sparse_vector_table_tb.sv
`timescale 1ns / 1ps

module sorted_sparse_vector_table_tb;

  localparam int TABLE_SLOTS = 64;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [20:0] FULL_LENGTH = 21'h10_0000;

  // one input transaction, packed lowest field first as on s_tdata
  typedef struct packed {
    logic [31:0] value;
    logic [19:0] index;
    logic [2:0]  action;
  } vec_op_t;

  // one result transaction, packed lowest field first as on m_tdata
  typedef struct packed {
    logic [6:0]  entry_count;
    logic [1:0]  status;
    logic [31:0] read_value;
  } vec_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        vector_length_we = 1'b0;
  logic [20:0] vector_length = FULL_LENGTH;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;

  sorted_sparse_vector_table i_dut (
    .clk              (clk),
    .rst              (rst),
    .vector_length_we (vector_length_we),
    .vector_length    (vector_length),
    .s_tvalid         (s_tvalid),
    .s_tready         (s_tready),
    .s_tdata          (s_tdata),
    .m_tvalid         (m_tvalid),
    .m_tready         (m_tready),
    .m_tdata          (m_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state: nonzero entries by index, kept in index order by the map
  logic [31:0]  stored_vals [logic [19:0]];
  logic [20:0]  cfg_length = FULL_LENGTH;

  vec_op_t      pending_ops [$];
  vec_result_t  expected_results [$];
  int unsigned  mismatch_count = 0;
  int unsigned  cycle_count = 0;
  int unsigned  send_gap = 0;
  int unsigned  recv_stall = 0;
  logic         in_taken = 1'b0;
  bit           idle_off = 1'b0;

  // mostly short gaps, a few long ones; none at all while idle_off is set
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (idle_off || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // zero removes, nonzero overwrites or inserts; insert into a full table drops
  function automatic logic [1:0] store_value(logic [19:0] idx, logic [31:0] val);
    if (val == '0) begin
      if (stored_vals.exists(idx)) stored_vals.delete(idx);
      return ssvt_pkg::ST_OK;
    end
    if (!stored_vals.exists(idx) && stored_vals.num() >= TABLE_SLOTS)
      return ssvt_pkg::ST_FULL;
    stored_vals[idx] = val;
    return ssvt_pkg::ST_OK;
  endfunction

  function automatic vec_result_t apply_vector_op(vec_op_t op);
    vec_result_t res;
    logic [31:0] cur;
    res = '0;
    res.status = ssvt_pkg::ST_OK;
    if (op.action == ssvt_pkg::ACT_CLEAR) begin
      stored_vals.delete();
    end else if (op.action <= ssvt_pkg::ACT_SUB) begin
      cur = stored_vals.exists(op.index) ? stored_vals[op.index] : '0;
      if ({1'b0, op.index} >= cfg_length) begin
        res.status = ssvt_pkg::ST_RANGE;
      end else if (op.action == ssvt_pkg::ACT_GET) begin
        res.read_value = cur;
      end else if (op.action == ssvt_pkg::ACT_SET) begin
        res.status = store_value(op.index, op.value);
      end else begin
        // wrapping accumulate; subtracting the most negative value wraps to itself
        res.status = store_value(op.index,
                                 (op.action == ssvt_pkg::ACT_ADD) ?
                                 cur + op.value : cur - op.value);
      end
    end
    res.entry_count = 7'(stored_vals.num());
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("%0t mismatch %s: got %h, expected %h", $time, what, got, want);
  endtask

  // sender: new transaction at the falling edge once the previous one is taken
  always @(negedge clk) begin
    vec_op_t op;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_taken) begin
      if (send_gap > 0) begin
        send_gap = send_gap - 1;
        s_tvalid <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        op = pending_ops.pop_front();
        s_tdata <= {1'b0, op};
        s_tvalid <= 1'b1;
        send_gap = pick_gap();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random back-pressure
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (recv_stall > 0) begin
      recv_stall = recv_stall - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      recv_stall = pick_gap();
    end
  end

  // monitor: check results first, then predict the transaction taken at this edge
  always @(posedge clk) begin
    vec_result_t got;
    vec_result_t want;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      if (!rst) begin
        cycle_count++;
        if (m_tvalid && m_tready) begin
          got = m_tdata[40:0];
          if (expected_results.size() == 0) begin
            report_mismatch("result with nothing pending", got.read_value, '0);
          end else begin
            want = expected_results.pop_front();
            if (got.read_value !== want.read_value)
              report_mismatch("read_value", got.read_value, want.read_value);
            if (got.status !== want.status)
              report_mismatch("status", 32'(got.status), 32'(want.status));
            if (got.entry_count !== want.entry_count)
              report_mismatch("entry_count", 32'(got.entry_count), 32'(want.entry_count));
          end
        end
        if (s_tvalid && s_tready)
          expected_results.push_back(apply_vector_op(vec_op_t'(s_tdata[54:0])));
      end
      in_taken <= !rst && s_tvalid && s_tready;
    end
  end

  task automatic queue_op(logic [2:0] act, logic [19:0] idx, logic [31:0] val);
    vec_op_t op;
    op.action = act;
    op.index  = idx;
    op.value  = val;
    pending_ops.push_back(op);
  endtask

  // register writes only while nothing is in flight
  task automatic write_length(logic [20:0] len);
    @(negedge clk);
    vector_length_we <= 1'b1;
    vector_length    <= len;
    @(negedge clk);
    vector_length_we <= 1'b0;
    cfg_length = len;
  endtask

  task automatic wait_idle();
    while (pending_ops.size() != 0 || s_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // mostly inside a narrow window so entries collide; some full-range and out-of-range
  function automatic logic [19:0] pick_index(int unsigned lim);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 6) return 20'($urandom());
    if (r < 11 && cfg_length < FULL_LENGTH)
      return 20'($urandom_range(cfg_length, 20'hF_FFFF));
    return 20'($urandom_range(0, lim - 1));
  endfunction

  // small values make sums cancel and drop entries
  function automatic logic [31:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) return $urandom_range(0, 8) - 4;
    if (r < 40) begin
      case ($urandom_range(0, 3))
        0: return 32'h7FFF_FFFF;
        1: return 32'h8000_0000;
        2: return 32'hFFFF_FFFF;
        default: return 32'h0000_0001;
      endcase
    end
    return $urandom();
  endfunction

  task automatic queue_random_ops(int unsigned count, int unsigned span);
    int unsigned made;
    int unsigned lim;
    int unsigned idx;
    int unsigned run_len;
    int unsigned r;
    logic [2:0] act;
    made = 0;
    lim = (cfg_length < span) ? cfg_length : span;
    while (made < count) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        // another vector's entries streamed in ascending index order
        act = $urandom_range(0, 1) ? ssvt_pkg::ACT_ADD : ssvt_pkg::ACT_SUB;
        run_len = $urandom_range(2, 8);
        idx = $urandom_range(0, lim - 1);
        for (int k = 0; k < run_len && idx < lim; k++) begin
          queue_op(act, idx[19:0], pick_value());
          idx += $urandom_range(1, 6);
          made++;
        end
      end else if (r < 75) begin
        queue_op(ssvt_pkg::ACT_SET, pick_index(lim), pick_value());
        made++;
      end else if (r < 87) begin
        queue_op(ssvt_pkg::ACT_GET, pick_index(lim), pick_value());
        made++;
      end else if (r < 93) begin
        // out-of-order noise
        queue_op($urandom_range(0, 1) ? ssvt_pkg::ACT_ADD : ssvt_pkg::ACT_SUB,
                 pick_index(lim), pick_value());
        made++;
      end else if (r < 96) begin
        queue_op(ssvt_pkg::ACT_CLEAR, 20'($urandom()), $urandom());
        made++;
      end else begin
        // unused action codes
        queue_op(3'($urandom_range(5, 7)), 20'($urandom()), $urandom());
      end
    end
  endtask

  int unsigned phase_length [7] = '{21'h10_0000, 64, 1, 1000, 21'h0F_FFFF, 200, 21'h10_0000};
  int unsigned phase_span   [7] = '{100, 64, 1, 120, 80, 200, 90};

  initial begin
    logic [31:0] val;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: field extremes, cancellation, wrap on negation, clear, unused codes
    queue_op(ssvt_pkg::ACT_SET, 20'd0, 32'h7FFF_FFFF);
    queue_op(ssvt_pkg::ACT_SET, 20'hF_FFFF, 32'h8000_0000);
    queue_op(ssvt_pkg::ACT_GET, 20'd0, 32'hFFFF_FFFF);
    queue_op(ssvt_pkg::ACT_GET, 20'hF_FFFF, 32'd0);
    queue_op(ssvt_pkg::ACT_GET, 20'd5, 32'd0);
    queue_op(ssvt_pkg::ACT_SET, 20'd7, 32'd0);
    queue_op(ssvt_pkg::ACT_ADD, 20'd9, 32'd0);
    queue_op(ssvt_pkg::ACT_SUB, 20'd9, 32'd0);
    queue_op(ssvt_pkg::ACT_SUB, 20'd3, 32'h8000_0000);
    queue_op(ssvt_pkg::ACT_GET, 20'd3, 32'd0);
    queue_op(ssvt_pkg::ACT_ADD, 20'd0, 32'h8000_0001);
    queue_op(ssvt_pkg::ACT_SET, 20'hF_FFFF, 32'd0);
    queue_op(ssvt_pkg::ACT_GET, 20'hF_FFFF, 32'd0);
    queue_op(3'd5, 20'hA_5A5A, 32'hDEAD_BEEF);
    queue_op(3'd6, 20'h5_A5A5, 32'h1234_5678);
    queue_op(3'd7, 20'hF_FFFF, 32'hFFFF_FFFF);
    queue_op(ssvt_pkg::ACT_CLEAR, 20'hF_FFFF, 32'hFFFF_FFFF);
    queue_op(ssvt_pkg::ACT_GET, 20'd3, 32'd0);
    wait_idle();

    // short vector: last valid index and the first invalid one
    write_length(21'd16);
    queue_op(ssvt_pkg::ACT_SET, 20'd15, 32'd5);
    queue_op(ssvt_pkg::ACT_SET, 20'd16, 32'd5);
    queue_op(ssvt_pkg::ACT_GET, 20'd16, 32'd0);
    queue_op(ssvt_pkg::ACT_ADD, 20'd20, 32'd1);
    queue_op(ssvt_pkg::ACT_SUB, 20'hF_FFFF, 32'd1);
    queue_op(ssvt_pkg::ACT_GET, 20'd15, 32'd0);
    wait_idle();
    write_length(21'd1);
    queue_op(ssvt_pkg::ACT_SET, 20'd0, 32'hFFFF_FFFF);
    queue_op(ssvt_pkg::ACT_SET, 20'd1, 32'd2);
    queue_op(ssvt_pkg::ACT_GET, 20'd0, 32'd0);
    wait_idle();

    // fill to capacity, inserting at the front each time
    write_length(FULL_LENGTH);
    queue_op(ssvt_pkg::ACT_CLEAR, 20'd0, 32'd0);
    for (int k = TABLE_SLOTS - 1; k >= 0; k--) begin
      val = $urandom();
      if (val == '0) val = 32'd1;
      queue_op(ssvt_pkg::ACT_SET, 20'(k * 3 + 1), val);
    end
    queue_op(ssvt_pkg::ACT_SET, 20'd0, 32'd9);
    queue_op(ssvt_pkg::ACT_ADD, 20'd2, 32'd9);
    queue_op(ssvt_pkg::ACT_SUB, 20'hF_FFFF, 32'd9);
    queue_op(ssvt_pkg::ACT_ADD, 20'd5, 32'd0);
    queue_op(ssvt_pkg::ACT_SET, 20'd1, 32'h7FFF_FFFF);
    queue_op(ssvt_pkg::ACT_SET, 20'd4, 32'd0);
    queue_op(ssvt_pkg::ACT_SET, 20'd0, 32'hFFFF_FFFF);
    queue_op(ssvt_pkg::ACT_GET, 20'd0, 32'd0);
    queue_op(ssvt_pkg::ACT_SET, 20'd2, 32'd3);
    wait_idle();

    for (int ph = 0; ph < 7; ph++) begin
      idle_off = (ph % 3 == 2);
      write_length(21'(phase_length[ph]));
      queue_random_ops(78, phase_span[ph]);
      wait_idle();
    end
    idle_off = 1'b0;

    repeat (80) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
